FILE: sv/bsg_pkg.sv
// Shared types, widths and constants of the Bezier segment generator.
package bsg_pkg;

   localparam int PointsLimit = 16;
   localparam int BinomW = 13;
   localparam int MulW = 27;
   localparam int ProdW = 2 * MulW;
   localparam int DivNumW = 41;
   localparam int DivDenW = 13;
   localparam int FracW = 24;
   localparam int CoordW = 18;
   localparam int PixW = 22;
   localparam int TW = FracW + 1;
   localparam int WgtW = 26;
   localparam int AccW = 48;
   localparam int P16W = AccW - FracW;
   localparam int OffW = 27;
   localparam int XnumW = 41;
   localparam int QmagW = 25;
   localparam int QuoW = 23;
   localparam int RecipShift = 29;

   localparam logic [TW-1:0] OneQ24 = TW'(1 << FracW);
   // 2^29 / 15 rounded up gives the exact floor quotient by 15 for operands below 2^25.
   localparam logic [MulW-1:0] Recip15 = MulW'(35791395);

   localparam int DefaultMaxPoints = 8;
   localparam logic [3:0] PointCountReset = 4'd4;
   localparam logic [9:0] SegmentCountReset = 10'd100;
   localparam logic [12:0] CanvasWidthReset = 13'd640;
   localparam logic [12:0] CanvasHeightReset = 13'd480;

   typedef enum logic [1:0] {
      CSR_POINT_COUNT   = 2'd0,
      CSR_SEGMENT_COUNT = 2'd1,
      CSR_CANVAS_WIDTH  = 2'd2,
      CSR_CANVAS_HEIGHT = 2'd3
   } bsg_csr_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EMIT = 1'b1
   } bsg_cmd_type;

   typedef struct packed {
      logic                start;
      logic [DivNumW-1:0] num;
      logic [DivDenW-1:0] den;
   } bsg_div_req_type;

   typedef logic [PointsLimit-1:0][BinomW-1:0] binom_row_type;
   typedef binom_row_type [PointsLimit-1:0] binom_tab_type;

   // Pascal's triangle, built at elaboration.
   function automatic binom_tab_type binom_build();
      binom_tab_type tab;
      tab = '0;
      tab[0][0] = BinomW'(1);
      for (int r = 1; r < PointsLimit; r++) begin
         tab[r][0] = BinomW'(1);
         for (int c = 1; c <= r; c++) begin
            tab[r][c] = tab[r-1][c-1] + tab[r-1][c];
         end
      end
      return tab;
   endfunction

   localparam binom_tab_type BinomTab = binom_build();

endpackage

FILE: sv/bsg_mul.sv
// Shared signed multiplier with a registered product.
module bsg_mul (
   input  logic                               clock,
   input  logic signed [bsg_pkg::MulW-1:0]    a,
   input  logic signed [bsg_pkg::MulW-1:0]    b,
   output logic signed [bsg_pkg::ProdW-1:0]   prod
);
   import bsg_pkg::*;

   logic signed [ProdW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule

FILE: sv/bsg_div.sv
// Restoring divider, one quotient bit per cycle.
module bsg_div (
   input  logic                              clock,
   input  logic                              reset,
   input  bsg_pkg::bsg_div_req_type          req,
   output logic                              done,
   output logic [bsg_pkg::DivNumW-1:0]       quotient
);
   import bsg_pkg::*;

   localparam int CntW = $clog2(DivNumW + 1);

   logic [DivDenW-1:0] rem_ff;
   logic [DivNumW-1:0] quo_ff;
   logic [DivDenW-1:0] den_ff;
   logic [CntW-1:0]    cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DivDenW:0]   rem_sh;
   logic [DivDenW+1:0] diff;

   assign rem_sh = {rem_ff, quo_ff[DivNumW-1]};
   assign diff = {1'b0, rem_sh} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff <= '0;
            quo_ff <= req.num;
            den_ff <= req.den;
            cnt_ff <= CntW'(DivNumW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!diff[DivDenW+1]) begin
               rem_ff <= diff[DivDenW-1:0];
               quo_ff <= {quo_ff[DivNumW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[DivDenW-1:0];
               quo_ff <= {quo_ff[DivNumW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held for two cycles");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff || $past(req.start)) else $error("divider stopped early");

endmodule

FILE: sv/bezier_segment_generator.sv
// Bezier flattener: a load word (tuser 0) stores one control point whose index is below
// MAX_POINTS and returns nothing; an emit word (tuser 1) returns one segment word after both
// endpoints have been evaluated on one shared 27x27 multiplier and one serial 41-bit divider
// for t. An emit keeps the input busy until its word is handed over: per endpoint it starts
// and finishes the division for t, clears the sums, runs the power steps, the Bernstein terms
// and the pixel mapping of each coordinate; after both endpoints it hands the word to the
// output. The end of the last segment is t = 1 and skips its division. The hand-off stalls
// while the previous segment still waits at the output, but a new word is taken as soon as
// the segment word has been placed in the output register.
module bezier_segment_generator #(
   parameter int MAX_POINTS = bsg_pkg::DefaultMaxPoints
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // point_index[2:0], point_x[20:3], point_y[38:21], segment_index[48:39], zero pad
   input  logic [55:0] req_tdata,
   // cmd
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // start_x[21:0], start_y[43:22], end_x[65:44], end_y[87:66]
   output logic [87:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import bsg_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);

   typedef enum logic [4:0] {
      IDLE, T_START, T_WAIT, POW_INIT, POW_T, POW_U, POW_UC,
      W_PROD, W_RND, W_BIN, W_WCAP, W_MX, W_MY, W_ACCY,
      P_RND, P_OFF, P_MUL, P_MCAP, P_DIV, P_RMUL, P_RCAP, FIN
   } state_type;

   state_type state_ff;

   logic [3:0]  point_count_ff;
   logic [9:0]  segment_count_ff;
   logic [12:0] canvas_width_ff;
   logic [12:0] canvas_height_ff;

   logic signed [CoordW-1:0] cx_ff [MAX_POINTS];
   logic signed [CoordW-1:0] cy_ff [MAX_POINTS];
   logic [TW-1:0] tp_ff [MAX_POINTS];
   logic [TW-1:0] up_ff [MAX_POINTS];

   logic [IW-1:0]  n_ff;
   logic [IW-1:0]  idx_ff;
   logic [9:0]     nseg_ff;
   logic [9:0]     k_ff;
   logic           pt_sel_ff;
   logic           coord_ff;
   logic [TW-1:0]  t_ff;
   logic [TW-1:0]  u_ff;
   logic [TW-1:0]  p24_ff;
   logic [WgtW-1:0] w_ff;
   logic signed [AccW-1:0] sx_ff;
   logic signed [AccW-1:0] sy_ff;
   logic signed [P16W-1:0] p16_ff;
   logic signed [OffW-1:0] off_ff;
   logic signed [XnumW-1:0] xnum_ff;
   logic [QmagW-1:0] qmag_ff;
   logic           neg_ff;
   logic [PixW-1:0] pix_ff [4];
   logic           rsp_valid_ff;
   logic [87:0]    rsp_data_ff;

   logic signed [MulW-1:0]  mul_a;
   logic signed [MulW-1:0]  mul_b;
   logic signed [ProdW-1:0] prod;
   logic [ProdW-1:0]        prod_rnd;
   logic [TW-1:0]           rnd24;
   bsg_div_req_type         div_req;
   logic                    div_done;
   logic [DivNumW-1:0]      div_quo;

   logic [2:0]              load_idx;
   logic [IW-1:0]           n_clamp;
   logic [9:0]              nseg_clamp;
   logic [9:0]              k_req;
   logic [10:0]             k_next;
   logic signed [AccW-1:0]  acc_rnd;
   logic [XnumW-10:0]       q512;
   logic [XnumW-9:0]        qmag_full;
   logic [QuoW-1:0]         quo15;
   logic signed [QuoW:0]    pix_val;
   logic [PixW-1:0]         pix_sat;
   logic [IW-1:0]           idx_up;

   assign load_idx = req_tdata[2:0];
   assign k_req = req_tdata[48:39];
   assign idx_up = IW'(idx_ff + IW'(1));

   always_comb begin
      if (point_count_ff < 4'd2) begin
         n_clamp = IW'(1);
      end else if (32'(point_count_ff) > MAX_POINTS) begin
         n_clamp = IW'(MAX_POINTS - 1);
      end else begin
         n_clamp = IW'(point_count_ff - 4'd1);
      end
      nseg_clamp = (segment_count_ff == 10'd0) ? 10'd1 : segment_count_ff;
   end

   assign k_next = {1'b0, k_ff} + 11'd1;
   assign prod_rnd = prod + ProdW'(1 << (FracW - 1));
   assign rnd24 = prod_rnd[FracW+TW-1:FracW];
   assign acc_rnd = (coord_ff ? sy_ff : sx_ff) + AccW'(1 << (FracW - 1));

   // The floor quotient by 7680 is the floor quotient by 512 followed by one by 15. A negative
   // value divides its magnitude plus 14 and negates the result.
   assign q512 = xnum_ff[XnumW-1:9];
   assign qmag_full = xnum_ff[XnumW-1] ? {1'b0, ~q512} + (XnumW-8)'(15) : {1'b0, q512};
   assign quo15 = prod[RecipShift +: QuoW];

   always_comb begin
      pix_val = neg_ff ? -$signed({1'b0, quo15}) : $signed({1'b0, quo15});
      if (pix_val > $signed((QuoW+1)'(2097151))) begin
         pix_sat = PixW'(2097151);
      end else if (pix_val < -$signed((QuoW+1)'(2097152))) begin
         pix_sat = PixW'(2097152);
      end else begin
         pix_sat = pix_val[PixW-1:0];
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         POW_T: begin
            mul_a = MulW'(tp_ff[idx_ff]);
            mul_b = MulW'(t_ff);
         end
         POW_U: begin
            mul_a = MulW'(up_ff[idx_ff]);
            mul_b = MulW'(u_ff);
         end
         W_PROD: begin
            mul_a = MulW'(tp_ff[idx_ff]);
            mul_b = MulW'(up_ff[IW'(n_ff - idx_ff)]);
         end
         W_BIN: begin
            mul_a = MulW'(BinomTab[4'(n_ff)][4'(idx_ff)]);
            mul_b = MulW'(p24_ff);
         end
         W_MX: begin
            mul_a = MulW'(w_ff);
            mul_b = MulW'(cx_ff[idx_ff]);
         end
         W_MY: begin
            mul_a = MulW'(w_ff);
            mul_b = MulW'(cy_ff[idx_ff]);
         end
         P_MUL: begin
            mul_a = off_ff;
            mul_b = MulW'(coord_ff ? canvas_height_ff : canvas_width_ff);
         end
         P_RMUL: begin
            mul_a = MulW'(qmag_ff);
            mul_b = Recip15;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_req = '0;
      if (state_ff == T_START && !(pt_sel_ff && k_next >= {1'b0, nseg_ff})) begin
         div_req.start = 1'b1;
         div_req.num = (DivNumW'(pt_sel_ff ? k_next : {1'b0, k_ff}) << FracW)
                       + DivNumW'(nseg_ff >> 1);
         div_req.den = DivDenW'(nseg_ff);
      end
   end

   bsg_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   bsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         point_count_ff <= PointCountReset;
         segment_count_ff <= SegmentCountReset;
         canvas_width_ff <= CanvasWidthReset;
         canvas_height_ff <= CanvasHeightReset;
      end else begin
         if (csr_we) begin
            unique case (bsg_csr_type'(csr_index))
               CSR_POINT_COUNT:   point_count_ff <= csr_wdata[3:0];
               CSR_SEGMENT_COUNT: segment_count_ff <= csr_wdata[9:0];
               CSR_CANVAS_WIDTH:  canvas_width_ff <= csr_wdata;
               CSR_CANVAS_HEIGHT: canvas_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && state_ff != FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  if (bsg_cmd_type'(req_tuser[0]) == CMD_LOAD) begin
                     if (32'(load_idx) < MAX_POINTS) begin
                        cx_ff[IW'(load_idx)] <= req_tdata[20:3];
                        cy_ff[IW'(load_idx)] <= req_tdata[38:21];
                     end
                  end else begin
                     n_ff <= n_clamp;
                     nseg_ff <= nseg_clamp;
                     k_ff <= (k_req >= nseg_clamp) ? nseg_clamp - 10'd1 : k_req;
                     idx_ff <= '0;
                     pt_sel_ff <= 1'b0;
                     state_ff <= T_START;
                  end
               end
            end
            T_START: begin
               if (pt_sel_ff && k_next >= {1'b0, nseg_ff}) begin
                  t_ff <= OneQ24;
                  u_ff <= '0;
                  state_ff <= POW_INIT;
               end else begin
                  state_ff <= T_WAIT;
               end
            end
            T_WAIT: begin
               if (div_done) begin
                  t_ff <= div_quo[TW-1:0];
                  u_ff <= OneQ24 - div_quo[TW-1:0];
                  state_ff <= POW_INIT;
               end
            end
            POW_INIT: begin
               tp_ff[0] <= OneQ24;
               up_ff[0] <= OneQ24;
               idx_ff <= '0;
               sx_ff <= '0;
               sy_ff <= '0;
               state_ff <= POW_T;
            end
            POW_T: state_ff <= POW_U;
            POW_U: begin
               tp_ff[idx_up] <= rnd24;
               state_ff <= POW_UC;
            end
            POW_UC: begin
               up_ff[idx_up] <= rnd24;
               if (idx_up == n_ff) begin
                  idx_ff <= '0;
                  state_ff <= W_PROD;
               end else begin
                  idx_ff <= idx_up;
                  state_ff <= POW_T;
               end
            end
            W_PROD: state_ff <= W_RND;
            W_RND: begin
               p24_ff <= rnd24;
               state_ff <= W_BIN;
            end
            W_BIN: state_ff <= W_WCAP;
            W_WCAP: begin
               w_ff <= prod[WgtW-1:0];
               state_ff <= W_MX;
            end
            W_MX: state_ff <= W_MY;
            W_MY: begin
               sx_ff <= sx_ff + AccW'(prod);
               state_ff <= W_ACCY;
            end
            W_ACCY: begin
               sy_ff <= sy_ff + AccW'(prod);
               if (idx_ff == n_ff) begin
                  coord_ff <= 1'b0;
                  state_ff <= P_RND;
               end else begin
                  idx_ff <= idx_up;
                  state_ff <= W_PROD;
               end
            end
            P_RND: begin
               p16_ff <= acc_rnd[AccW-1:FracW];
               state_ff <= P_OFF;
            end
            P_OFF: begin
               off_ff <= (OffW'(p16_ff) <<< 2) + OffW'(p16_ff) + OffW'(196608);
               state_ff <= P_MUL;
            end
            P_MUL: state_ff <= P_MCAP;
            P_MCAP: begin
               xnum_ff <= {prod[XnumW-2:0], 1'b0} + XnumW'(3840);
               state_ff <= P_DIV;
            end
            P_DIV: begin
               // Magnitudes past 2^25 saturate the pixel whatever their exact quotient.
               qmag_ff <= (qmag_full >= (XnumW-8)'(1 << QmagW)) ? '1
                                                               : qmag_full[QmagW-1:0];
               neg_ff <= xnum_ff[XnumW-1];
               state_ff <= P_RMUL;
            end
            P_RMUL: state_ff <= P_RCAP;
            P_RCAP: begin
               pix_ff[{pt_sel_ff, coord_ff}] <= pix_sat;
               if (!coord_ff) begin
                  coord_ff <= 1'b1;
                  state_ff <= P_RND;
               end else if (!pt_sel_ff) begin
                  pt_sel_ff <= 1'b1;
                  state_ff <= T_START;
               end else begin
                  state_ff <= FIN;
               end
            end
            FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff <= {pix_ff[3], pix_ff[2], pix_ff[1], pix_ff[0]};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_emit_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("emit word did not start evaluation");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != IDLE && state_ff != T_START |-> idx_ff <= n_ff)
      else $error("term index passed the curve degree");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FIN))
      else $error("segment word raised outside completion");
   a_wait_no_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_WAIT |-> !div_req.start)
      else $error("divider started while a quotient is awaited");

endmodule
